@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/fcm_pkg.sv @@
package fcm_pkg;

  localparam int TABLE_ENTRIES = 8192;
  localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int FILE_SLOTS    = 128;
  localparam int SLOT_W        = 7;
  localparam int BLOCK_BYTES   = 4096;
  localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int LINK_W        = 16;
  localparam int CNT_W         = 14;
  localparam int CMD_W         = 3;
  localparam int OFFSET_W      = 26;
  localparam int STEP_W        = OFFSET_W - BLOCK_SHIFT;
  localparam int DBC_RESET     = 8192;

  localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ENTRY = 3'd0,
    CMD_LOAD_FIRST = 3'd1,
    CMD_LOCATE     = 3'd2,
    CMD_APPEND     = 3'd3,
    CMD_FREE_CHAIN = 3'd4,
    CMD_COUNT_FREE = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0] block;
    logic [CNT_W-1:0]  free_count;
    logic              status;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] waddr;
    logic [LINK_W-1:0]   wdata;
    logic [TABLE_AW-1:0] raddr;
  } link_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } slot_port_t;

endpackage

@@ hdl/fcm_if.sv @@
interface fcm_in_if;
  import fcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SLOT_W-1:0]   file_slot;
  logic [TABLE_AW-1:0] entry_address;
  logic [LINK_W-1:0]   entry_value;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (
    output valid, command, file_slot, entry_address, entry_value, byte_offset,
    input  ready
  );
  modport sink (
    input  valid, command, file_slot, entry_address, entry_value, byte_offset,
    output ready
  );
endinterface

interface fcm_out_if;
  import fcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] block;
  logic [CNT_W-1:0]  free_count;
  logic              status;

  modport source (
    output valid, block, free_count, status,
    input  ready
  );
  modport sink (
    input  valid, block, free_count, status,
    output ready
  );
endinterface

@@ hdl/fcm_ram.sv @@
module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fcm_out_reg.sv @@
module fcm_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  fcm_pkg::result_t load_data,
  fcm_out_if.source        out_ch
);
  import fcm_pkg::*;

  logic    valid;
  result_t data;

  assign load_ready = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_valid && load_ready) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= load_data;
    end
  end

  assign out_ch.valid      = valid;
  assign out_ch.block      = data.block;
  assign out_ch.free_count = data.free_count;
  assign out_ch.status     = data.status;

endmodule

@@ hdl/fcm_seq.sv @@
`include "assert_macros.svh"

module fcm_seq (
  input  logic                        clk,
  input  logic                        rst,
  fcm_in_if.sink                      in_ch,
  input  logic [fcm_pkg::CNT_W-1:0]   data_block_count,
  output fcm_pkg::link_port_t         link_port,
  input  logic [fcm_pkg::LINK_W-1:0]  link_rdata,
  output fcm_pkg::slot_port_t         slot_port,
  input  logic [fcm_pkg::LINK_W-1:0]  slot_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fcm_pkg::result_t            res
);
  import fcm_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_FB       = 10'b00_0000_0100,
    S_HEAD     = 10'b00_0000_1000,
    S_WALK_RD  = 10'b00_0001_0000,
    S_WALK_CHK = 10'b00_0010_0000,
    S_SCAN     = 10'b00_0100_0000,
    S_LINK1    = 10'b00_1000_0000,
    S_LINK2    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    idx, idx_next;
  cmd_t                cmd, cmd_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic [STEP_W-1:0]   steps, steps_next;
  logic [LINK_W-1:0]   b, b_next;
  logic [LINK_W-1:0]   head, head_next;
  logic [CNT_W-1:0]    s, s_next;
  logic                chk_v, chk_v_next;
  logic [TABLE_AW-1:0] chk_idx, chk_idx_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [TABLE_AW-1:0] found, found_next;
  result_t             res_next;

  logic [CNT_W-1:0]    lim;
  logic                slot_ok;
  logic                b_in;
  logic                issue;
  logic                hit;

  assign lim     = (32'(data_block_count) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                            : data_block_count;
  assign slot_ok = 32'(in_ch.file_slot) < FILE_SLOTS;
  assign b_in    = 32'(b) < TABLE_ENTRIES;
  assign issue   = idx < lim;
  assign hit     = chk_v && (link_rdata == '0);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd_next     = cmd;
    slot_next    = slot;
    steps_next   = steps;
    b_next       = b;
    head_next    = head;
    s_next       = s;
    chk_v_next   = 1'b0;
    chk_idx_next = chk_idx;
    cnt_next     = cnt;
    found_next   = found;
    res_next     = res;
    link_port       = '0;
    link_port.raddr = b[TABLE_AW-1:0];
    slot_port       = '0;
    slot_port.raddr = slot;
    in_ch.ready  = 1'b0;
    res_valid    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        link_port.we    = 1'b1;
        link_port.waddr = idx[TABLE_AW-1:0];
        link_port.wdata = '0;
        if (32'(idx) < FILE_SLOTS) begin
          slot_port.we    = 1'b1;
          slot_port.waddr = idx[SLOT_W-1:0];
          slot_port.wdata = END_MARK;
        end
        if (32'(idx) == TABLE_ENTRIES - 1) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_next   = cmd_t'(in_ch.command);
          slot_next  = in_ch.file_slot;
          steps_next = in_ch.byte_offset[OFFSET_W-1:BLOCK_SHIFT];
          res_next.block      = END_MARK;
          res_next.free_count = '0;
          res_next.status     = 1'b0;
          state_next          = S_DONE;
          case (in_ch.command)
            CMD_LOAD_ENTRY: begin
              link_port.we    = 1'b1;
              link_port.waddr = in_ch.entry_address;
              link_port.wdata = in_ch.entry_value;
            end
            CMD_LOAD_FIRST: begin
              if (slot_ok) begin
                slot_port.we    = 1'b1;
                slot_port.waddr = in_ch.file_slot;
                slot_port.wdata = in_ch.entry_value;
              end else begin
                res_next.status = 1'b1;
              end
            end
            CMD_LOCATE, CMD_APPEND, CMD_FREE_CHAIN: begin
              if (slot_ok) begin
                state_next = S_FB;
              end else begin
                res_next.status = 1'b1;
              end
            end
            CMD_COUNT_FREE: begin
              idx_next   = '0;
              cnt_next   = '0;
              state_next = S_SCAN;
            end
            default: begin
              res_next.status = 1'b1;
            end
          endcase
        end
      end

      S_FB: begin
        state_next = S_HEAD;
      end

      S_HEAD: begin
        b_next    = slot_rdata;
        head_next = slot_rdata;
        s_next    = '0;
        if (cmd == CMD_APPEND && slot_rdata == END_MARK) begin
          idx_next   = '0;
          state_next = S_SCAN;
        end else if (cmd == CMD_APPEND && !(32'(slot_rdata) < TABLE_ENTRIES)) begin
          res_next.status = 1'b1;
          state_next      = S_DONE;
        end else begin
          state_next = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        state_next = S_WALK_CHK;
        case (cmd)
          CMD_LOCATE: begin
            if (s == steps || b == END_MARK) begin
              res_next.block  = b;
              res_next.status = (b == END_MARK);
              state_next      = S_DONE;
            end else if (!b_in) begin
              res_next.block  = END_MARK;
              res_next.status = 1'b1;
              state_next      = S_DONE;
            end
          end
          CMD_FREE_CHAIN: begin
            if (b == END_MARK || !b_in || !(32'(s) < TABLE_ENTRIES)) begin
              slot_port.we    = 1'b1;
              slot_port.waddr = slot;
              slot_port.wdata = END_MARK;
              state_next      = S_DONE;
            end
          end
          default: begin
          end
        endcase
      end

      S_WALK_CHK: begin
        state_next = S_WALK_RD;
        case (cmd)
          CMD_LOCATE: begin
            b_next = link_rdata;
            s_next = s + 1'b1;
          end
          CMD_FREE_CHAIN: begin
            link_port.we    = 1'b1;
            link_port.waddr = b[TABLE_AW-1:0];
            link_port.wdata = '0;
            b_next          = link_rdata;
            s_next          = s + 1'b1;
          end
          default: begin
            if (link_rdata == END_MARK) begin
              idx_next   = '0;
              state_next = S_SCAN;
            end else begin
              b_next = link_rdata;
              s_next = s + 1'b1;
              if (!(32'(link_rdata) < TABLE_ENTRIES) || 32'(s) + 1 >= TABLE_ENTRIES) begin
                res_next.status = 1'b1;
                state_next      = S_DONE;
              end
            end
          end
        endcase
      end

      S_SCAN: begin
        link_port.raddr = idx[TABLE_AW-1:0];
        chk_v_next      = issue;
        chk_idx_next    = idx[TABLE_AW-1:0];
        if (issue) begin
          idx_next = idx + 1'b1;
        end
        if (cmd == CMD_APPEND) begin
          if (hit) begin
            found_next = chk_idx;
            chk_v_next = 1'b0;
            state_next = S_LINK1;
          end else if (!issue && !chk_v) begin
            res_next.status = 1'b1;
            state_next      = S_DONE;
          end
        end else begin
          if (hit) begin
            cnt_next = cnt + 1'b1;
          end
          if (!issue && !chk_v) begin
            res_next.free_count = cnt;
            state_next          = S_DONE;
          end
        end
      end

      S_LINK1: begin
        if (head == END_MARK) begin
          slot_port.we    = 1'b1;
          slot_port.waddr = slot;
          slot_port.wdata = LINK_W'(found);
        end else begin
          link_port.we    = 1'b1;
          link_port.waddr = b[TABLE_AW-1:0];
          link_port.wdata = LINK_W'(found);
        end
        state_next = S_LINK2;
      end

      S_LINK2: begin
        link_port.we    = 1'b1;
        link_port.waddr = found;
        link_port.wdata = END_MARK;
        res_next.block  = LINK_W'(found);
        state_next      = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      chk_v <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      chk_v <= chk_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    slot    <= slot_next;
    steps   <= steps_next;
    b       <= b_next;
    head    <= head_next;
    s       <= s_next;
    chk_idx <= chk_idx_next;
    cnt     <= cnt_next;
    found   <= found_next;
    res     <= res_next;
  end

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_ch.valid && in_ch.ready, state != S_IDLE, "accepted beat did not start work")
  `ASSERT_IMPLIES(a_no_write_in_scan, clk, rst, state == S_SCAN, !link_port.we, "table written during scan")
  `ASSERT_IMPLIES(a_scan_bound, clk, rst, state == S_SCAN, 32'(idx) <= TABLE_ENTRIES, "scan index past table")
  `ASSERT_NEXT(a_done_handoff, clk, rst, res_valid && res_ready, state == S_IDLE, "result handoff did not return to idle")

endmodule

@@ hdl/fat_chain_manager.sv @@
// commands: each load writes one entry or slot; locate walks the file's chain, free chain
// clears it, append links the first free entry to its end; count free scans the table
// one output beat per input beat, held in the output register; one item at a time
// the single-port-write table memory and its one read port set the pace of walks and scans
// reset: synchronous, active high; a clearing pass empties the table and file slots
// before the first input beat is taken
module fat_chain_manager (
  input  logic                      clk,
  input  logic                      rst,
  fcm_in_if.sink                    in_ch,
  fcm_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [fcm_pkg::CNT_W-1:0] cfg_wdata
);
  import fcm_pkg::*;

  logic [CNT_W-1:0]  data_block_count;
  link_port_t        link_port;
  logic [LINK_W-1:0] link_rdata;
  slot_port_t        slot_port;
  logic [LINK_W-1:0] slot_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_block_count <= CNT_W'(DBC_RESET);
    end else if (cfg_we) begin
      data_block_count <= cfg_wdata;
    end
  end

  fcm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_port.we),
    .waddr (link_port.waddr),
    .wdata (link_port.wdata),
    .raddr (link_port.raddr),
    .rdata (link_rdata)
  );

  fcm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (FILE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_port.we),
    .waddr (slot_port.waddr),
    .wdata (slot_port.wdata),
    .raddr (slot_port.raddr),
    .rdata (slot_rdata)
  );

  fcm_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (in_ch),
    .data_block_count (data_block_count),
    .link_port        (link_port),
    .link_rdata       (link_rdata),
    .slot_port        (slot_port),
    .slot_rdata       (slot_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  fcm_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_valid),
    .load_ready (res_ready),
    .load_data  (res),
    .out_ch     (out_ch)
  );

endmodule
